FILE: rtl/core/multi_channel_deadline_watchdog_top_assert.svh
// assertion macros shared by the watchdog modules
`ifndef MULTI_CHANNEL_DEADLINE_WATCHDOG_TOP_ASSERT_SVH
`define MULTI_CHANNEL_DEADLINE_WATCHDOG_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define MCDW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("watchdog assertion failed");

// consequent checked in the next cycle
`define MCDW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("watchdog assertion failed");

`endif

FILE: rtl/core/mcdw_pkg.sv
package mcdw_pkg;

    localparam int CHANNELS  = 16;
    localparam int TIME_BITS = 32;
    localparam int MAX_FIRE  = 16;

    localparam int IDX_W  = $clog2(CHANNELS);
    localparam int CH_W   = 4;
    localparam int AMT_W  = 32;
    localparam int KIND_W = 3;
    localparam int CMP_W  = (IDX_W > CH_W) ? IDX_W : CH_W;
    localparam int FIRE_W = $clog2(MAX_FIRE + 1);
    localparam int WAIT_W = $clog2(CHANNELS + 1);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_RELOAD = 3'd3,
        KIND_ABS    = 3'd4,
        KIND_REL    = 3'd5
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmd_valid;
        kind_t            kind;
        logic [CH_W-1:0]  channel;
        time_t            amount;
        time_t            now;
        logic             clear_done;
        logic             fire;
        logic [IDX_W-1:0] fire_idx;
    } ctl_t;

    // best candidate handed along the chain
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        time_t            age;
    } scan_t;

endpackage

FILE: rtl/core/mcdw_cell.sv
module mcdw_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [mcdw_pkg::IDX_W-1:0]     cell_idx,
    input  mcdw_pkg::ctl_t                 ctl,
    input  mcdw_pkg::scan_t                scan_in,
    output mcdw_pkg::scan_t                scan_out
);

`include "multi_channel_deadline_watchdog_top_assert.svh"

    logic              active_reg;
    logic              done_reg;
    mcdw_pkg::time_t   period_reg;
    mcdw_pkg::time_t   deadline_reg;
    mcdw_pkg::scan_t   scan_reg;
    mcdw_pkg::scan_t   scan_next;

    logic              hit;
    logic              fire_hit;
    logic              due;
    mcdw_pkg::time_t   age;
    mcdw_pkg::time_t   amt_nz;

    assign hit      = (mcdw_pkg::CMP_W'(ctl.channel) == mcdw_pkg::CMP_W'(cell_idx));
    assign fire_hit = ctl.fire && (ctl.fire_idx == cell_idx);
    assign age      = ctl.now - deadline_reg;
    assign due      = active_reg && !done_reg && !age[mcdw_pkg::TIME_BITS-1];
    assign amt_nz   = (ctl.amount == '0) ? mcdw_pkg::TIME_BITS'(1) : ctl.amount;

    always_comb begin
        scan_next = scan_in;
        if (due && (!scan_in.found || age > scan_in.age)) begin
            scan_next.found = 1'b1;
            scan_next.idx   = cell_idx;
            scan_next.age   = age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            scan_reg   <= '0;
        end else begin
            scan_reg <= scan_next;
            if (ctl.clear_done) begin
                done_reg <= 1'b0;
            end
            if (fire_hit) begin
                done_reg <= 1'b1;
            end
            if (ctl.cmd_valid && hit) begin
                unique case (ctl.kind)
                    mcdw_pkg::KIND_ADD:    active_reg <= 1'b1;
                    mcdw_pkg::KIND_REMOVE: active_reg <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_hit) begin
            deadline_reg <= ctl.now + period_reg;
        end
        if (ctl.cmd_valid && hit) begin
            unique case (ctl.kind)
                mcdw_pkg::KIND_ADD: begin
                    period_reg   <= amt_nz;
                    deadline_reg <= ctl.now + amt_nz;
                end
                mcdw_pkg::KIND_RELOAD: begin
                    if (active_reg) deadline_reg <= ctl.now + period_reg;
                end
                mcdw_pkg::KIND_ABS: begin
                    if (active_reg) deadline_reg <= ctl.amount;
                end
                mcdw_pkg::KIND_REL: begin
                    if (active_reg) deadline_reg <= ctl.now + ctl.amount;
                end
                default: ;
            endcase
        end
    end

    assign scan_out = scan_reg;

    `MCDW_ASSERT_SAME(a_fire_only_due, fire_hit, active_reg && !done_reg)
    `MCDW_ASSERT_NEXT(a_clear_done, ctl.clear_done, !done_reg)
    `MCDW_ASSERT_NEXT(a_add_activates, ctl.cmd_valid && hit && ctl.kind == mcdw_pkg::KIND_ADD, active_reg)

endmodule

FILE: rtl/core/multi_channel_deadline_watchdog_top.sv
// Watchdog bank of CHANNELS channels built as a chain of cells, one cell per channel,
// each holding its active mark, period, deadline and a fired-this-tick flag. Add,
// remove and the three re-arm commands leave the input ready, so the next item can
// follow straight after. A tick advances the shared time counter and then runs one
// pass of the cell chain per firing plus a closing pass: the earliest-deadline
// candidate travels one cell per cycle, and a tick occupies the input until all its
// passes are done, plus any wait for the result side to take items. At most MAX_FIRE
// channels fire per tick, lowest index first on equal deadlines; the final firing of
// a tick carries last.
module multi_channel_deadline_watchdog_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mcdw_pkg::KIND_W-1:0]   s_kind,
    input  logic [mcdw_pkg::CH_W-1:0]     s_channel,
    input  logic [mcdw_pkg::AMT_W-1:0]    s_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcdw_pkg::CH_W-1:0]     m_fired_channel,
    output logic                          m_last
);

`include "multi_channel_deadline_watchdog_top_assert.svh"

    mcdw_pkg::state_t               state_reg, state_next;
    mcdw_pkg::time_t                now_reg, now_next;
    logic [mcdw_pkg::WAIT_W-1:0]    wait_reg, wait_next;
    logic [mcdw_pkg::FIRE_W-1:0]    count_reg, count_next;
    logic                           hold_valid_reg, hold_valid_next;
    logic [mcdw_pkg::IDX_W-1:0]     hold_idx_reg, hold_idx_next;
    logic                           m_valid_reg, m_valid_next;
    logic [mcdw_pkg::CH_W-1:0]      m_chan_reg, m_chan_next;
    logic                           m_last_reg, m_last_next;

    mcdw_pkg::ctl_t                 ctl;
    mcdw_pkg::scan_t                scan_w [mcdw_pkg::CHANNELS+1];
    mcdw_pkg::scan_t                best;
    logic                           out_free;

    assign scan_w[0] = '0;

    for (genvar g = 0; g < mcdw_pkg::CHANNELS; g++) begin : g_cell
        mcdw_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (mcdw_pkg::IDX_W'(g)),
            .ctl      (ctl),
            .scan_in  (scan_w[g]),
            .scan_out (scan_w[g+1])
        );
    end

    assign best     = scan_w[mcdw_pkg::CHANNELS];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mcdw_pkg::ST_IDLE;
            now_reg        <= '0;
            wait_reg       <= '0;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            wait_reg       <= wait_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_idx_reg <= hold_idx_next;
        m_chan_reg   <= m_chan_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        wait_next       = wait_reg;
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        m_valid_next    = m_valid_reg;
        m_chan_next     = m_chan_reg;
        m_last_next     = m_last_reg;
        s_ready         = 1'b0;
        ctl             = '0;
        ctl.now         = now_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mcdw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == mcdw_pkg::KIND_TICK) begin
                        now_next        = now_reg + mcdw_pkg::TIME_BITS'(1);
                        ctl.clear_done  = 1'b1;
                        wait_next       = mcdw_pkg::WAIT_W'(mcdw_pkg::CHANNELS);
                        count_next      = '0;
                        hold_valid_next = 1'b0;
                        state_next      = mcdw_pkg::ST_SCAN;
                    end else begin
                        ctl.cmd_valid = 1'b1;
                        ctl.kind      = mcdw_pkg::kind_t'(s_kind);
                        ctl.channel   = s_channel;
                        ctl.amount    = mcdw_pkg::TIME_BITS'(s_amount);
                    end
                end
            end
            mcdw_pkg::ST_SCAN: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (out_free) begin
                    if (best.found && count_reg < mcdw_pkg::FIRE_W'(mcdw_pkg::MAX_FIRE)) begin
                        ctl.fire        = 1'b1;
                        ctl.fire_idx    = best.idx;
                        wait_next       = mcdw_pkg::WAIT_W'(mcdw_pkg::CHANNELS);
                        count_next      = count_reg + 1'b1;
                        hold_valid_next = 1'b1;
                        hold_idx_next   = best.idx;
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_chan_next  = mcdw_pkg::CH_W'(hold_idx_reg);
                            m_last_next  = 1'b0;
                        end
                    end else begin
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_chan_next  = mcdw_pkg::CH_W'(hold_idx_reg);
                            m_last_next  = 1'b1;
                        end
                        hold_valid_next = 1'b0;
                        state_next      = mcdw_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = mcdw_pkg::ST_IDLE;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_fired_channel = m_chan_reg;
    assign m_last          = m_last_reg;

    `MCDW_ASSERT_NEXT(a_tick_advances, s_valid && s_ready && s_kind == mcdw_pkg::KIND_TICK, now_reg == $past(now_reg) + mcdw_pkg::TIME_BITS'(1))
    `MCDW_ASSERT_SAME(a_idle_no_hold, state_reg == mcdw_pkg::ST_IDLE, !hold_valid_reg)
    `MCDW_ASSERT_SAME(a_fire_found, ctl.fire, best.found && count_reg < mcdw_pkg::FIRE_W'(mcdw_pkg::MAX_FIRE))

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import mcdw_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 400;
    localparam int N_ITEMS     = 230;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   ch;
        logic [AMT_W-1:0]  amt;
    } wd_cmd_t;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic            last;
    } firing_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = '0;
    logic [CH_W-1:0]     s_channel = '0;
    logic [AMT_W-1:0]    s_amount = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CH_W-1:0]     m_fired_channel;
    logic                m_last;

    wd_cmd_t cmd_q[$];
    firing_t firing_q[$];

    // own copy of the watchdog bank
    logic  wd_active [CHANNELS];
    time_t wd_period [CHANNELS];
    time_t wd_deadline [CHANNELS];
    time_t wd_now;

    int    n_queued;
    time_t gen_now;
    int    n_sent;
    int    n_ticks;
    int    most_fired;
    int    n_results;
    int    mismatches;
    int    burst_left;
    int    gap_left;
    int    hold_left;
    logic  hold_done;
    logic [31:0] rx_cycle;
    int    idle_cycles;
    wd_cmd_t next_cmd;

    multi_channel_deadline_watchdog_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_channel       (s_channel),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fired_channel (m_fired_channel),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic apply_command(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                                 input logic [AMT_W-1:0] amt);
        logic [CHANNELS-1:0] fired;
        time_t               age;
        time_t               best_age;
        int                  best;
        int                  n_fired;
        firing_t             f;
        fired   = '0;
        n_fired = 0;
        case (kind)
            KIND_TICK: begin
                wd_now = wd_now + 1'b1;
                n_ticks++;
                for (int k = 0; k < MAX_FIRE; k++) begin
                    best     = -1;
                    best_age = '0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        age = wd_now - wd_deadline[c];
                        if (wd_active[c] && !fired[c] && !age[TIME_BITS-1]
                                && (best < 0 || age > best_age)) begin
                            best     = c;
                            best_age = age;
                        end
                    end
                    if (best >= 0) begin
                        fired[best]       = 1'b1;
                        wd_deadline[best] = wd_now + wd_period[best];
                        f.ch   = best[CH_W-1:0];
                        f.last = 1'b0;
                        firing_q.push_back(f);
                        n_fired++;
                    end
                end
                if (n_fired > 0) begin
                    f      = firing_q.pop_back();
                    f.last = 1'b1;
                    firing_q.push_back(f);
                end
                if (n_fired > most_fired) most_fired = n_fired;
            end
            KIND_ADD: begin
                wd_period[ch]   = (amt == '0) ? time_t'(1) : amt;
                wd_deadline[ch] = wd_now + wd_period[ch];
                wd_active[ch]   = 1'b1;
            end
            KIND_REMOVE: wd_active[ch] = 1'b0;
            KIND_RELOAD: if (wd_active[ch]) wd_deadline[ch] = wd_now + wd_period[ch];
            KIND_ABS:    if (wd_active[ch]) wd_deadline[ch] = amt;
            KIND_REL:    if (wd_active[ch]) wd_deadline[ch] = wd_now + amt;
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [KIND_W-1:0] kind, input int ch, input logic [31:0] amt);
        wd_cmd_t c;
        c.kind = kind;
        c.ch   = ch[CH_W-1:0];
        c.amt  = amt;
        cmd_q.push_back(c);
        n_queued++;
        if (kind == KIND_TICK) gen_now = gen_now + 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 20) $display("tb: mismatch: %s", what);
        mismatches++;
    endtask

    // driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_command(s_kind, s_channel, s_amount);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    next_cmd = cmd_q.pop_front();
                    s_kind    <= next_cmd.kind;
                    s_channel <= next_cmd.ch;
                    s_amount  <= next_cmd.amt;
                    s_valid   <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_cycle  = '0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && n_results >= 30) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_cycle[7:6])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= 1'($urandom_range(0, 1));
                    2'd2: m_ready <= (rx_cycle[1:0] == 2'd0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        firing_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results <= n_results + 1;
            if (firing_q.size() == 0) begin
                report_mismatch($sformatf("unexpected firing of channel %0d", m_fired_channel));
            end else begin
                e = firing_q.pop_front();
                if (m_fired_channel !== e.ch)
                    report_mismatch($sformatf("fired_channel %0d, expected %0d",
                                              m_fired_channel, e.ch));
                if (m_last !== e.last)
                    report_mismatch($sformatf("last %0b, expected %0b on channel %0d",
                                              m_last, e.last, e.ch));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: timeout, %0d firings still expected", firing_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int ch;
        for (int c = 0; c < CHANNELS; c++) begin
            wd_active[c]   = 1'b0;
            wd_period[c]   = '0;
            wd_deadline[c] = '0;
        end
        wd_now      = '0;
        gen_now     = '0;
        n_queued    = 0;
        n_sent      = 0;
        n_ticks     = 0;
        most_fired  = 0;
        n_results   = 0;
        mismatches  = 0;
        idle_cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: inactive channels, unused kinds, extremes, ties, long periods
        queue_cmd(KIND_TICK, 0, 32'hFFFF_FFFF);
        queue_cmd(KIND_REMOVE, 5, '0);
        queue_cmd(KIND_RELOAD, 5, '0);
        queue_cmd(KIND_ABS, 5, 32'hFFFF_FFFF);
        queue_cmd(KIND_REL, 5, 32'h0000_0003);
        queue_cmd(3'd6, 15, $urandom);
        queue_cmd(3'd7, 10, $urandom);
        queue_cmd(KIND_ADD, 0, 32'h0);
        queue_cmd(KIND_ADD, 15, 32'hFFFF_FFFF);
        queue_cmd(KIND_ADD, 1, 32'd2);
        queue_cmd(KIND_ADD, 2, 32'd2);
        queue_cmd(KIND_ADD, 3, 32'h8000_0001);
        queue_cmd(KIND_ADD, 4, 32'h8000_0000);
        queue_cmd(KIND_TICK, 15, '0);
        queue_cmd(KIND_TICK, 7, 32'h5555_5555);
        queue_cmd(KIND_TICK, 8, 32'hAAAA_AAAA);
        queue_cmd(KIND_ABS, 1, 32'h0);
        queue_cmd(KIND_REL, 2, 32'h0);
        queue_cmd(KIND_RELOAD, 0, '0);
        queue_cmd(KIND_TICK, 0, '0);
        queue_cmd(KIND_REMOVE, 15, '0);
        queue_cmd(KIND_REMOVE, 3, '0);
        queue_cmd(KIND_ADD, 0, 32'h0);
        queue_cmd(KIND_TICK, 0, '0);
        queue_cmd(KIND_TICK, 0, '0);

        // sender pauses until every firing has come out
        while (cmd_q.size() > 0 || s_valid || firing_q.size() > 0) @(negedge aclk);

        // every channel added with a short period, then ticks
        for (int c = 0; c < CHANNELS; c++) queue_cmd(KIND_ADD, c, $urandom_range(1, 3));
        repeat (3) queue_cmd(KIND_TICK, $urandom_range(0, 15), $urandom);

        while (n_queued < N_ITEMS) begin
            r  = $urandom_range(0, 99);
            ch = $urandom_range(0, CHANNELS - 1);
            if (r < 45) begin
                queue_cmd(KIND_TICK, ch, $urandom);
            end else if (r < 60) begin
                case ($urandom_range(0, 6))
                    0:       queue_cmd(KIND_ADD, ch, $urandom);
                    1:       queue_cmd(KIND_ADD, ch, 32'h7FFF_FFFE + $urandom_range(0, 3));
                    default: queue_cmd(KIND_ADD, ch, $urandom_range(0, 12));
                endcase
            end else if (r < 68) begin
                queue_cmd(KIND_REMOVE, ch, $urandom);
            end else if (r < 76) begin
                queue_cmd(KIND_RELOAD, ch, $urandom);
            end else if (r < 86) begin
                if ($urandom_range(0, 3) == 0) queue_cmd(KIND_ABS, ch, $urandom);
                else queue_cmd(KIND_ABS, ch, gen_now + $urandom_range(0, 12) - 32'd3);
            end else if (r < 94) begin
                if ($urandom_range(0, 3) == 0) queue_cmd(KIND_REL, ch, $urandom);
                else queue_cmd(KIND_REL, ch, $urandom_range(0, 10));
            end else if (r < 97) begin
                queue_cmd(3'd6 + 3'($urandom_range(0, 1)), ch, $urandom);
            end else begin
                for (int c = 0; c < CHANNELS; c++) queue_cmd(KIND_ADD, c, $urandom_range(1, 3));
                repeat (2) queue_cmd(KIND_TICK, ch, $urandom);
            end
        end

        while (cmd_q.size() > 0 || s_valid || firing_q.size() > 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("tb: %0d items sent, %0d ticks, %0d firings checked, up to %0d in one tick",
                 n_sent, n_ticks, n_results, most_fired);
        $display("tb: receiver hold-off of %0d cycles done: %0b", HOLD_CYCLES, hold_done);
        if (mismatches == 0 && firing_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
